FILE: sv/energy_voice_activity_detector_defines.svh
// ----------------------------------------------------------------------------
// Voice activity detector assertion macros
// Shared concurrent assertion forms, sampled on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_DEFINES_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_DEFINES_SVH

// same-cycle implication
`define EVAD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EVAD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/evad_pkg.sv
// ----------------------------------------------------------------------------
// Voice activity detector package
// Widths, register indexes, event codes and shared types.
// ----------------------------------------------------------------------------
package evad_pkg;

   localparam int SampleW         = 16;
   localparam int SumW            = 28;
   localparam int CountW          = 13;
   localparam int TimeW           = 32;
   localparam int LevelW          = 16;
   localparam int EventW          = 2;
   localparam int LoudW           = 8;
   localparam int QuietW          = 16;
   localparam int DurW            = 10;
   localparam int ProdW           = QuietW + DurW;
   localparam int MaxFrameSamples = 4096;
   localparam int FifoDepth       = 2;
   localparam int FifoPtrW        = 1;
   localparam int DivSteps        = SumW;
   localparam int DivCntW         = 5;
   localparam int RemW            = CountW + 1;
   localparam int CsrIndexW       = 8;
   localparam int CsrDataW        = 32;

   localparam logic [EventW-1:0] EVT_NONE  = 2'd0;
   localparam logic [EventW-1:0] EVT_START = 2'd1;
   localparam logic [EventW-1:0] EVT_END   = 2'd2;

   localparam logic [CsrIndexW-1:0] REG_START_THRESHOLD   = 8'd0;
   localparam logic [CsrIndexW-1:0] REG_END_THRESHOLD     = 8'd1;
   localparam logic [CsrIndexW-1:0] REG_START_FRAME_COUNT = 8'd2;
   localparam logic [CsrIndexW-1:0] REG_FRAME_DURATION_MS = 8'd3;
   localparam logic [CsrIndexW-1:0] REG_SILENCE_END_MS    = 8'd4;
   localparam logic [CsrIndexW-1:0] REG_MAX_LISTEN_MS     = 8'd5;

   typedef struct packed {
      logic [SumW-1:0]   abs_sum;
      logic [CountW-1:0] sample_count;
      logic [TimeW-1:0]  now_ms;
   } frame_type;

   typedef struct packed {
      logic [LevelW-1:0] start_threshold;
      logic [LevelW-1:0] end_threshold;
      logic [LoudW-1:0]  start_frame_count;
      logic [DurW-1:0]   frame_duration_ms;
      logic [QuietW-1:0] silence_end_ms;
      logic [TimeW-1:0]  max_listen_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      start_threshold:   16'd800,
      end_threshold:     16'd400,
      start_frame_count: 8'd3,
      frame_duration_ms: 10'd32,
      silence_end_ms:    16'd800,
      max_listen_ms:     32'd10000
   };

endpackage

FILE: sv/evad_if.sv
// ----------------------------------------------------------------------------
// Voice activity detector channels
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface evad_req_if
   import evad_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [SampleW-1:0] sample;
   logic                     frame_end;
   logic [TimeW-1:0]         now_ms;

   modport source (output valid, output sample, output frame_end, output now_ms,
                   input ready);
   modport sink   (input valid, input sample, input frame_end, input now_ms,
                   output ready);
endinterface

interface evad_rsp_if
   import evad_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [EventW-1:0] vad_event;
   logic [LevelW-1:0] frame_level;

   modport source (output valid, output vad_event, output frame_level, input ready);
   modport sink   (input valid, input vad_event, input frame_level, output ready);
endinterface

interface evad_csr_if
   import evad_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CsrIndexW-1:0] index;
   logic [CsrDataW-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/evad_front.sv
// ----------------------------------------------------------------------------
// Voice activity detector front end
// Accumulates sample magnitudes and hands each closed frame to the queue.
// ----------------------------------------------------------------------------
module evad_front
   import evad_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [SampleW-1:0] sample,
   input  logic                      frame_end,
   input  logic [TimeW-1:0]          now_ms,
   input  logic                      q_full,
   output logic                      q_push,
   output frame_type                 q_frame
);

   logic [SumW-1:0]    sum_ff, sum_in;
   logic [CountW-1:0]  cnt_ff, cnt_in;
   logic [SampleW-1:0] raw;
   logic [SampleW-1:0] mag;
   logic               room;
   logic [SumW-1:0]    sum_cur;
   logic [CountW-1:0]  cnt_cur;
   logic               accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   // -32768 wraps to 0x8000, which is its magnitude
   assign raw  = sample;
   assign mag  = raw[SampleW-1] ? (~raw + 1'b1) : raw;
   assign room = cnt_ff < CountW'(MaxFrameSamples);

   assign sum_cur = room ? (sum_ff + SumW'(mag)) : sum_ff;
   assign cnt_cur = room ? (cnt_ff + 1'b1) : cnt_ff;

   assign q_push  = accept && frame_end;
   assign q_frame = '{abs_sum: sum_cur, sample_count: cnt_cur, now_ms: now_ms};

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         if (frame_end) begin
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = sum_cur;
            cnt_in = cnt_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: sv/evad_fifo.sv
// ----------------------------------------------------------------------------
// Voice activity detector frame queue
// Short queue of closed frames between front and back end.
// ----------------------------------------------------------------------------
module evad_fifo
   import evad_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_frame,
   input  logic      pop,
   output frame_type head_frame,
   output logic      full,
   output logic      empty
);

   frame_type           mem_ff [FifoDepth];
   logic [FifoPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FifoPtrW:0]   cnt_ff, cnt_in;

   assign full       = cnt_ff == (FifoPtrW+1)'(FifoDepth);
   assign empty      = cnt_ff == '0;
   assign head_frame = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: sv/evad_back.sv
// ----------------------------------------------------------------------------
// Voice activity detector back end
// Serial frame-level divide, hysteresis decision and result register.
// ----------------------------------------------------------------------------
module evad_back
   import evad_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  frame_type         head_frame,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [EventW-1:0] vad_event,
   output logic [LevelW-1:0] frame_level
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [DivCntW-1:0] step_ff, step_in;
   logic [SumW-1:0]    quo_ff, quo_in;
   logic [RemW-1:0]    rem_ff, rem_in;
   logic [CountW-1:0]  div_ff, div_in;
   logic [TimeW-1:0]   now_ff, now_in;

   logic               speaking_ff, speaking_in;
   logic [LoudW-1:0]   loud_ff, loud_in;
   logic [QuietW-1:0]  quiet_ff, quiet_in;
   logic [TimeW-1:0]   start_time_ff, start_time_in;

   logic               out_valid_ff, out_valid_in;
   logic [EventW-1:0]  event_ff, event_in;
   logic [LevelW-1:0]  level_ff, level_in;

   logic [RemW-1:0]    rem_shift;
   logic               q_bit;
   logic               load;
   logic [LevelW-1:0]  level;
   logic [LoudW-1:0]   loud_inc;
   logic [QuietW-1:0]  quiet_inc;
   logic [QuietW-1:0]  quiet_upd;
   logic [ProdW-1:0]   quiet_ms;
   logic [TimeW-1:0]   elapsed;

   assign out_valid   = out_valid_ff;
   assign vad_event   = event_ff;
   assign frame_level = level_ff;

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;
   assign load  = (state_ff == ST_DONE) && (!out_valid_ff || out_ready);

   // restoring divide, one quotient bit per cycle, quotient shifts in behind the dividend
   assign rem_shift = {rem_ff[RemW-2:0], quo_ff[SumW-1]};
   assign q_bit     = rem_shift >= RemW'(div_ff);

   // mean of 16-bit magnitudes never exceeds 32768
   assign level     = quo_ff[LevelW-1:0];
   assign loud_inc  = (loud_ff == '1) ? loud_ff : loud_ff + 1'b1;
   assign quiet_inc = (quiet_ff == '1) ? quiet_ff : quiet_ff + 1'b1;
   assign quiet_upd = (level < cfg.end_threshold) ? quiet_inc : '0;
   assign quiet_ms  = ProdW'(quiet_upd) * ProdW'(cfg.frame_duration_ms);
   assign elapsed   = now_ff - start_time_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      now_in        = now_ff;
      speaking_in   = speaking_ff;
      loud_in       = loud_ff;
      quiet_in      = quiet_ff;
      start_time_in = start_time_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      event_in      = event_ff;
      level_in      = level_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               quo_in   = head_frame.abs_sum;
               div_in   = head_frame.sample_count;
               now_in   = head_frame.now_ms;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = q_bit ? (rem_shift - RemW'(div_ff)) : rem_shift;
            quo_in  = {quo_ff[SumW-2:0], q_bit};
            step_in = step_ff + 1'b1;
            if (step_ff == DivCntW'(DivSteps - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               out_valid_in = 1'b1;
               level_in     = level;
               event_in     = EVT_NONE;
               if (!speaking_ff) begin
                  if (level >= cfg.start_threshold) begin
                     loud_in = loud_inc;
                     if (loud_inc >= cfg.start_frame_count) begin
                        speaking_in   = 1'b1;
                        quiet_in      = '0;
                        start_time_in = now_ff;
                        event_in      = EVT_START;
                     end
                  end else begin
                     loud_in = '0;
                  end
               end else begin
                  quiet_in = quiet_upd;
                  if ((quiet_ms >= ProdW'(cfg.silence_end_ms)) ||
                      (elapsed >= cfg.max_listen_ms)) begin
                     speaking_in = 1'b0;
                     loud_in     = '0;
                     quiet_in    = '0;
                     event_in    = EVT_END;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      now_ff   <= now_in;
      step_ff  <= step_in;
      event_ff <= event_in;
      level_ff <= level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         speaking_ff   <= 1'b0;
         loud_ff       <= '0;
         quiet_ff      <= '0;
         start_time_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         speaking_ff   <= speaking_in;
         loud_ff       <= loud_in;
         quiet_ff      <= quiet_in;
         start_time_ff <= start_time_in;
         out_valid_ff  <= out_valid_in;
      end
   end

endmodule

FILE: sv/energy_voice_activity_detector.sv
// ----------------------------------------------------------------------------
// Energy voice activity detector
// A closing word's frame is queued, run through the 28-step divide, then registered.
// One sample word per cycle while the queue has room; one frame divides at a time.
// Reset: synchronous, active high; control and config registers return to defaults.
// ----------------------------------------------------------------------------
`include "energy_voice_activity_detector_defines.svh"

module energy_voice_activity_detector
   import evad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   evad_req_if.sink    req_ch,
   evad_rsp_if.source  rsp_ch,
   evad_csr_if.sink    csr_ch
);

   cfg_type   cfg_ff, cfg_in;
   frame_type push_frame;
   frame_type head_frame;
   logic      q_push;
   logic      q_pop;
   logic      q_full;
   logic      q_empty;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_START_THRESHOLD:   cfg_in.start_threshold   = csr_ch.data[LevelW-1:0];
            REG_END_THRESHOLD:     cfg_in.end_threshold     = csr_ch.data[LevelW-1:0];
            REG_START_FRAME_COUNT: cfg_in.start_frame_count = csr_ch.data[LoudW-1:0];
            REG_FRAME_DURATION_MS: cfg_in.frame_duration_ms = csr_ch.data[DurW-1:0];
            REG_SILENCE_END_MS:    cfg_in.silence_end_ms    = csr_ch.data[QuietW-1:0];
            REG_MAX_LISTEN_MS:     cfg_in.max_listen_ms     = csr_ch.data[TimeW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   evad_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .sample    (req_ch.sample),
      .frame_end (req_ch.frame_end),
      .now_ms    (req_ch.now_ms),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_frame   (push_frame)
   );

   evad_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_frame (push_frame),
      .pop        (q_pop),
      .head_frame (head_frame),
      .full       (q_full),
      .empty      (q_empty)
   );

   evad_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_frame  (head_frame),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .vad_event   (rsp_ch.vad_event),
      .frame_level (rsp_ch.frame_level)
   );

   `EVAD_ASSERT_NOW(a_no_overflow, q_push, !q_full, "frame queue overflow")
   `EVAD_ASSERT_NOW(a_no_underflow, q_pop, !q_empty, "frame queue underflow")
   `EVAD_ASSERT_NEXT(a_push_lands, q_push && !q_pop, !q_empty, "pushed frame lost")
   `EVAD_ASSERT_NOW(a_event_code, rsp_ch.valid, (rsp_ch.vad_event == EVT_NONE) || (rsp_ch.vad_event == EVT_START) || (rsp_ch.vad_event == EVT_END), "bad event code")

endmodule

FILE: tb/energy_voice_activity_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Energy voice activity detector testbench
// Streams PCM sample words with random gaps on both channels and predicts
// every frame decision. Each result word is checked against the prediction.
// The run goes through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_tb;
   import evad_pkg::*;

   localparam int CycleLimit    = 1_000_000;
   localparam int IdlePct       = 21;
   localparam int RspHoldCycles = 400;
   localparam int SettleCycles  = 40;
   localparam int FullScale     = 32768;

   typedef struct packed {
      logic signed [SampleW-1:0] sample;
      logic                      frame_end;
      logic [TimeW-1:0]          now_ms;
   } pcm_word_type;

   typedef struct packed {
      logic [EventW-1:0] vad_event;
      logic [LevelW-1:0] frame_level;
   } decision_type;

   logic clock;
   logic reset;

   evad_req_if req_if();
   evad_rsp_if rsp_if();
   evad_csr_if csr_if();

   energy_voice_activity_detector DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // predicted detector state and registers
   cfg_type           vad_cfg;
   logic              in_speech;
   logic [LoudW-1:0]  loud_run;
   logic [QuietW-1:0] quiet_run;
   logic [TimeW-1:0]  speech_t0;
   logic [SumW-1:0]   mag_sum;
   logic [CountW-1:0] mag_count;

   pcm_word_type sample_q[$];
   decision_type decision_q[$];

   logic [TimeW-1:0] ms_clock = 32'hFFFF_0000;
   logic no_idle = 1'b0;
   logic hold_go = 1'b0;
   int   hold_cnt = 0;
   int   cycles = 0;
   int   errors = 0;
   int   n_words = 0;
   int   n_frames = 0;
   int   n_starts = 0;
   int   n_ends = 0;

   wire rsp_holding = hold_go && (hold_cnt < RspHoldCycles);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver hold-off, counted here so the sender keeps offering meanwhile
   always @(posedge clock) begin
      if (rsp_holding) hold_cnt <= hold_cnt + 1;
   end

   always @(posedge clock) begin : driver
      pcm_word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (sample_q.size() > 0 && (no_idle || $urandom_range(99, 0) >= IdlePct)) begin
            w = sample_q.pop_front();
            req_if.valid     <= 1'b1;
            req_if.sample    <= w.sample;
            req_if.frame_end <= w.frame_end;
            req_if.now_ms    <= w.now_ms;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : predictor
      int                mag;
      logic [LevelW-1:0] level;
      logic [EventW-1:0] evt;
      logic [TimeW-1:0]  elapsed;
      logic [ProdW-1:0]  quiet_ms;
      if (!reset && req_if.valid && req_if.ready) begin
         n_words++;
         mag = int'(req_if.sample);
         if (mag < 0) mag = -mag;
         // a full frame drops the rest of its words, the closing one too
         if (mag_count < MaxFrameSamples) begin
            mag_sum   = mag_sum + mag;
            mag_count = mag_count + 1'b1;
         end
         if (req_if.frame_end) begin
            level     = mag_sum / mag_count;
            mag_sum   = '0;
            mag_count = '0;
            evt       = EVT_NONE;
            if (!in_speech) begin
               if (level >= vad_cfg.start_threshold) begin
                  if (loud_run != '1) loud_run = loud_run + 1'b1;
                  if (loud_run >= vad_cfg.start_frame_count) begin
                     in_speech = 1'b1;
                     quiet_run = '0;
                     speech_t0 = req_if.now_ms;
                     evt       = EVT_START;
                  end
               end else begin
                  loud_run = '0;
               end
            end else begin
               if (level < vad_cfg.end_threshold) begin
                  if (quiet_run != '1) quiet_run = quiet_run + 1'b1;
               end else begin
                  quiet_run = '0;
               end
               elapsed  = req_if.now_ms - speech_t0;
               quiet_ms = quiet_run * vad_cfg.frame_duration_ms;
               if (quiet_ms >= vad_cfg.silence_end_ms || elapsed >= vad_cfg.max_listen_ms) begin
                  in_speech = 1'b0;
                  loud_run  = '0;
                  quiet_run = '0;
                  evt       = EVT_END;
               end
            end
            decision_q.push_back('{vad_event: evt, frame_level: level});
         end
      end
   end

   always @(posedge clock) begin : monitor
      decision_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (decision_q.size() == 0) begin
               $display("%0t: unexpected result word, vad_event %0d frame_level %0d",
                        $time, rsp_if.vad_event, rsp_if.frame_level);
               errors++;
            end else begin
               want = decision_q.pop_front();
               n_frames++;
               if (want.vad_event == EVT_START) n_starts++;
               if (want.vad_event == EVT_END) n_ends++;
               if (rsp_if.vad_event !== want.vad_event) begin
                  $display("%0t: vad_event expected %0d actual %0d",
                           $time, want.vad_event, rsp_if.vad_event);
                  errors++;
               end
               if (rsp_if.frame_level !== want.frame_level) begin
                  $display("%0t: frame_level expected %0d actual %0d",
                           $time, want.frame_level, rsp_if.frame_level);
                  errors++;
               end
            end
         end
         rsp_if.ready <= !rsp_holding && (no_idle || $urandom_range(99, 0) >= IdlePct);
      end
   end

   task automatic push_word(input int s, input logic fe, input logic [TimeW-1:0] now);
      sample_q.push_back('{sample: s[SampleW-1:0], frame_end: fe, now_ms: now});
   endtask

   // one frame of n words, magnitudes in [lo, hi], stamped with the advancing clock
   task automatic push_frame(input int n, input int lo, input int hi);
      int mag;
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 3) ms_clock = ms_clock + $urandom();
      else if (roll < 6) ms_clock = ms_clock + vad_cfg.max_listen_ms;
      else ms_clock = ms_clock + vad_cfg.frame_duration_ms + $urandom_range(3, 0);
      for (int i = 0; i < n; i++) begin
         mag = $urandom_range(hi, lo);
         push_word((mag == FullScale || $urandom_range(1, 0) == 1) ? -mag : mag,
                   i == n - 1, (i == n - 1) ? ms_clock : $urandom());
      end
   endtask

   function automatic int frame_len();
      return ($urandom_range(9, 0) == 0) ? $urandom_range(40, 5) : $urandom_range(4, 1);
   endfunction

   // mostly loud runs followed by quiet runs, some full-range noise frames
   task automatic run_episodes(input int budget);
      int used;
      int lim;
      int lo_loud;
      int hi_quiet;
      int need;
      int len;
      int runs;
      used     = 0;
      lim      = (vad_cfg.start_frame_count > 30) ? 30 : int'(vad_cfg.start_frame_count);
      lo_loud  = (vad_cfg.start_threshold > FullScale) ? FullScale : int'(vad_cfg.start_threshold);
      hi_quiet = (vad_cfg.end_threshold == 0) ? 0 :
                 (vad_cfg.end_threshold > FullScale) ? FullScale :
                 int'(vad_cfg.end_threshold) - 1;
      need     = (vad_cfg.frame_duration_ms == 0) ? 6 :
                 (int'(vad_cfg.silence_end_ms) + int'(vad_cfg.frame_duration_ms) - 1) /
                 int'(vad_cfg.frame_duration_ms);
      if (need > 70) need = 70;
      while (used < budget) begin
         if ($urandom_range(99, 0) < 80) begin
            runs = $urandom_range(lim + 2, (lim > 1) ? lim - 1 : 0);
            repeat (runs) begin
               len = frame_len();
               push_frame(len, lo_loud, FullScale);
               used += len;
            end
            runs = $urandom_range(need + 2, 0);
            repeat (runs) begin
               len = frame_len();
               push_frame(len, 0, hi_quiet);
               used += len;
            end
         end else begin
            runs = $urandom_range(4, 1);
            repeat (runs) begin
               len = frame_len();
               push_frame(len, 0, FullScale);
               used += len;
            end
         end
      end
   endtask

   // call at a rising edge; valid is left high for back-to-back writes
   task automatic write_reg(input logic [CsrIndexW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         REG_START_THRESHOLD:   vad_cfg.start_threshold   = data[LevelW-1:0];
         REG_END_THRESHOLD:     vad_cfg.end_threshold     = data[LevelW-1:0];
         REG_START_FRAME_COUNT: vad_cfg.start_frame_count = data[LoudW-1:0];
         REG_FRAME_DURATION_MS: vad_cfg.frame_duration_ms = data[DurW-1:0];
         REG_SILENCE_END_MS:    vad_cfg.silence_end_ms    = data[QuietW-1:0];
         REG_MAX_LISTEN_MS:     vad_cfg.max_listen_ms     = data[TimeW-1:0];
         default: ;
      endcase
   endtask

   // junk fills the bits above each register width and adds a write to an unused index
   task automatic set_config(input cfg_type c, input logic junk);
      logic [CsrDataW-1:0] hi;
      hi = junk ? $urandom() : '0;
      write_reg(REG_START_THRESHOLD,   {hi[CsrDataW-1:LevelW], c.start_threshold});
      write_reg(REG_END_THRESHOLD,     {hi[CsrDataW-1:LevelW], c.end_threshold});
      write_reg(REG_START_FRAME_COUNT, {hi[CsrDataW-1:LoudW], c.start_frame_count});
      write_reg(REG_FRAME_DURATION_MS, {hi[CsrDataW-1:DurW], c.frame_duration_ms});
      write_reg(REG_SILENCE_END_MS,    {hi[CsrDataW-1:QuietW], c.silence_end_ms});
      write_reg(REG_MAX_LISTEN_MS,     c.max_listen_ms);
      if (junk) write_reg(CsrIndexW'($urandom_range(255, 6)), $urandom());
      csr_if.valid <= 1'b0;
   endtask

   // returns at a rising edge once the block has gone quiet
   task automatic drain();
      do @(negedge clock);
      while (sample_q.size() != 0 || req_if.valid || decision_q.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   initial begin
      cfg_type phase_cfg;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.sample    = '0;
      req_if.frame_end = 1'b0;
      req_if.now_ms    = '0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = '0;
      csr_if.data      = '0;
      vad_cfg          = CFG_RESET;
      in_speech        = 1'b0;
      loud_run         = '0;
      quiet_run        = '0;
      speech_t0        = '0;
      mag_sum          = '0;
      mag_count        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings, receiver held off at first so the input backs up
      hold_go <= 1'b1;
      @(negedge clock);
      run_episodes(150);
      drain();

      // directed: level extremes, threshold edges, silence end, listen limit, time wrap
      phase_cfg = '{start_threshold: 16'd800, end_threshold: 16'd400, start_frame_count: 8'd2,
                    frame_duration_ms: 10'd32, silence_end_ms: 16'd64,
                    max_listen_ms: 32'd10000};
      set_config(phase_cfg, 1'b0);
      @(negedge clock);
      push_word(32767, 1'b1, 32'hFFFF_FF00);
      push_word(-32768, 1'b1, 32'hFFFF_FFE0);
      push_word(0, 1'b0, $urandom());
      push_word(-1, 1'b1, 32'h0000_0000);
      push_word(399, 1'b1, 32'h0000_0020);
      push_word(800, 1'b1, 32'h0000_0040);
      push_word(799, 1'b1, 32'h0000_0050);
      push_word(800, 1'b1, 32'h0000_0060);
      push_word(800, 1'b0, $urandom());
      push_word(801, 1'b0, $urandom());
      push_word(799, 1'b1, 32'd100);
      push_word(400, 1'b1, 32'd130);
      push_word(20000, 1'b1, 32'd10100);
      push_word(-1, 1'b1, 32'd10132);
      drain();

      // mid settings, register writes carry junk above each width
      phase_cfg = '{start_threshold: 16'd2000, end_threshold: 16'd1500, start_frame_count: 8'd4,
                    frame_duration_ms: 10'd20, silence_end_ms: 16'd200,
                    max_listen_ms: 32'd3000};
      set_config(phase_cfg, 1'b1);
      @(negedge clock);
      run_episodes(120);
      drain();

      // all-zero settings, zero start count, no idling on either side
      phase_cfg = '{start_threshold: 16'd0, end_threshold: 16'd0, start_frame_count: 8'd0,
                    frame_duration_ms: 10'd0, silence_end_ms: 16'd0, max_listen_ms: 32'd0};
      set_config(phase_cfg, 1'b1);
      no_idle <= 1'b1;
      @(negedge clock);
      run_episodes(100);
      drain();
      no_idle <= 1'b0;

      // top settings
      phase_cfg = '{start_threshold: 16'h8000, end_threshold: 16'h8000, start_frame_count: 8'd1,
                    frame_duration_ms: 10'd1000, silence_end_ms: 16'hFFFF,
                    max_listen_ms: 32'hFFFF_FFFF};
      set_config(phase_cfg, 1'b0);
      @(negedge clock);
      run_episodes(80);
      drain();

      // a long loud run climbs all the way to the largest start count of 255
      phase_cfg = '{start_threshold: 16'd0, end_threshold: 16'd100, start_frame_count: 8'd255,
                    frame_duration_ms: 10'd10, silence_end_ms: 16'd30,
                    max_listen_ms: 32'd5000};
      set_config(phase_cfg, 1'b0);
      @(negedge clock);
      repeat (260) push_frame(1, 0, FullScale);
      run_episodes(60);
      drain();

      set_config(CFG_RESET, 1'b1);
      @(negedge clock);
      run_episodes(100);
      drain();

      $display("Checked %0d frame decisions (%0d speech starts, %0d speech ends) over %0d words",
               n_frames, n_starts, n_ends, n_words);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
